### design/pwic_pkg.sv
// ----------------------------------------------------------------------------
// pwic_pkg: shared types and constants for the PID controller
// Register indexes, the configuration bundle and datapath widths.
// ----------------------------------------------------------------------------
package pwic_pkg;

   localparam int ANGLE_W   = 16;
   localparam int ERR_W     = 17;
   localparam int SUM_W     = 18;
   localparam int DELTA_W   = 18;
   localparam int KP_W      = 16;
   localparam int KI_W      = 24;
   localparam int KD_W      = 24;
   localparam int LIMIT_W   = 17;
   localparam int DRIVE_W   = 16;
   localparam int P_W       = KP_W + ERR_W;
   localparam int I_W       = KI_W + SUM_W;
   localparam int D_W       = KD_W + DELTA_W;
   localparam int ACC_W     = 60;
   localparam int GAIN_SH   = 16;
   localparam int FRAC_BITS = 24;
   localparam int Q_W       = ACC_W - FRAC_BITS;
   localparam int INDEX_W   = 4;
   localparam int WDATA_W   = 24;
   localparam int REQ_W     = 2 * ANGLE_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128000);

   typedef enum logic [INDEX_W-1:0] {
      REG_KP             = 4'd0,
      REG_KI_DT          = 4'd1,
      REG_KD_PER_DT      = 4'd2,
      REG_INTEGRAL_LIMIT = 4'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [KP_W-1:0]   kp;
      logic signed [KI_W-1:0]   ki_dt;
      logic signed [KD_W-1:0]   kd_per_dt;
      logic        [LIMIT_W-1:0] integral_limit;
   } pid_cfg_type;

endpackage

### design/pwic_csr.sv
// ----------------------------------------------------------------------------
// pwic_csr: configuration registers
// Decodes register writes into the gain and clamp-limit bundle.
// ----------------------------------------------------------------------------
module pwic_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwic_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pwic_pkg::WDATA_W-1:0]  csr_wdata,
   output pwic_pkg::pid_cfg_type         cfg
);
   import pwic_pkg::*;

   pid_cfg_type cfg_ff;
   pid_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_KP:             cfg_in.kp             = csr_wdata[KP_W-1:0];
            REG_KI_DT:          cfg_in.ki_dt          = csr_wdata[KI_W-1:0];
            REG_KD_PER_DT:      cfg_in.kd_per_dt      = csr_wdata[KD_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp             <= '0;
         cfg_ff.ki_dt          <= '0;
         cfg_ff.kd_per_dt      <= '0;
         cfg_ff.integral_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/pid_with_integral_clamp.sv
// ----------------------------------------------------------------------------
// pid_with_integral_clamp: PID controller with a clamped integral term
// Four-stage pipeline from angle samples to a saturated drive value.
// ----------------------------------------------------------------------------
// Each sample transfer yields one drive transfer, and a new sample can be
// taken every cycle unless all stages are full. The first stage forms the
// error, the clamped error sum and the error difference and updates the
// controller state, the second holds the three gain products, the third
// their sum, and the result register truncates toward zero and saturates.
// Stages fill bubbles independently, so samples still enter while a result waits.
// Gains should be written only while no sample is in flight.
module pid_with_integral_clamp (
   input  logic                          clock,
   input  logic                          reset,
   // tdata: measured_angle [15:0], setpoint [31:16]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pwic_pkg::REQ_W-1:0]    req_tdata,
   // tdata: drive [15:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pwic_pkg::DRIVE_W-1:0]  rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwic_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pwic_pkg::WDATA_W-1:0]  csr_wdata
);
   import pwic_pkg::*;

   pid_cfg_type cfg;

   pwic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Controller state
   logic signed [ERR_W-1:0]   prev_error_ff, prev_error_in;
   logic signed [SUM_W-1:0]   error_sum_ff, error_sum_in;

   // Pipeline valids
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_free, s2_free, s3_free, out_free;
   logic accept;

   // Pipeline payload
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [P_W-1:0]     p_ff, p_in;
   logic signed [I_W-1:0]     i_ff, i_in;
   logic signed [D_W-1:0]     d_ff, d_in;
   logic signed [ACC_W-1:0]   total_ff, total_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;

   // Stage-one arithmetic
   logic signed [ANGLE_W-1:0] meas;
   logic signed [ANGLE_W-1:0] setp;
   logic signed [ERR_W-1:0]   err_c;
   logic signed [SUM_W:0]     sum_raw;
   logic signed [SUM_W:0]     lim_pos;
   logic signed [SUM_W:0]     lim_neg;
   logic signed [SUM_W:0]     sum_clamped;

   // Output arithmetic
   logic signed [ACC_W-1:0]   bias;
   logic signed [ACC_W-1:0]   total_adj;
   logic signed [Q_W-1:0]     q;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s3_free    = !s3_valid_ff || out_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      meas    = req_tdata[ANGLE_W-1:0];
      setp    = req_tdata[REQ_W-1:ANGLE_W];
      err_c   = {meas[ANGLE_W-1], meas} - {setp[ANGLE_W-1], setp};
      sum_raw = {error_sum_ff[SUM_W-1], error_sum_ff}
              + {{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c};
      lim_pos = {{(SUM_W+1-LIMIT_W){1'b0}}, cfg.integral_limit};
      lim_neg = -lim_pos;
      if (sum_raw > lim_pos) begin
         sum_clamped = lim_pos;
      end else if (sum_raw < lim_neg) begin
         sum_clamped = lim_neg;
      end else begin
         sum_clamped = sum_raw;
      end

      prev_error_in = prev_error_ff;
      error_sum_in  = error_sum_ff;
      err_in        = err_ff;
      sum_in        = sum_ff;
      delta_in      = delta_ff;
      if (accept) begin
         prev_error_in = err_c;
         error_sum_in  = sum_clamped[SUM_W-1:0];
         err_in        = err_c;
         sum_in        = sum_clamped[SUM_W-1:0];
         delta_in      = {err_c[ERR_W-1], err_c} - {prev_error_ff[ERR_W-1], prev_error_ff};
      end
   end

   always_comb begin
      p_in = p_ff;
      i_in = i_ff;
      d_in = d_ff;
      if (s2_free) begin
         p_in = P_W'(cfg.kp) * P_W'(err_ff);
         i_in = I_W'(cfg.ki_dt) * I_W'(sum_ff);
         d_in = D_W'(cfg.kd_per_dt) * D_W'(delta_ff);
      end
   end

   always_comb begin
      total_in = total_ff;
      if (s3_free) begin
         total_in = {{(ACC_W-P_W-GAIN_SH){p_ff[P_W-1]}}, p_ff, {GAIN_SH{1'b0}}}
                  + {{(ACC_W-I_W){i_ff[I_W-1]}}, i_ff}
                  + {{(ACC_W-D_W-GAIN_SH){d_ff[D_W-1]}}, d_ff, {GAIN_SH{1'b0}}};
      end
   end

   // A negative total is biased before the shift so that it rounds toward zero.
   always_comb begin
      bias      = total_ff[ACC_W-1] ? {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0;
      total_adj = total_ff + bias;
      q         = total_adj[ACC_W-1:FRAC_BITS];
      drive_in  = drive_ff;
      if (out_free) begin
         if (q > Q_W'(32767)) begin
            drive_in = 16'sh7FFF;
         end else if (q < -Q_W'(32768)) begin
            drive_in = 16'sh8000;
         end else begin
            drive_in = q[DRIVE_W-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_free  ? req_tvalid   : s1_valid_ff;
      s2_valid_in  = s2_free  ? s1_valid_ff  : s2_valid_ff;
      s3_valid_in  = s3_free  ? s2_valid_ff  : s3_valid_ff;
      out_valid_in = out_free ? s3_valid_ff  : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         error_sum_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prev_error_ff <= prev_error_in;
         error_sum_ff  <= error_sum_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      sum_ff   <= sum_in;
      delta_ff <= delta_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      d_ff     <= d_in;
      total_ff <= total_in;
      drive_ff <= drive_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;

   // The state after a transfer carries that sample's error.
   a_prev_error_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> prev_error_ff == err_ff)
      else $error("prev_error does not match the accepted sample's error");

   // The input side only stalls when every stage is occupied.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && out_valid_ff))
      else $error("input stalled while the pipeline has a bubble");

   // A waiting sum stage is never dropped while the result is stalled.
   a_s3_held: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !out_free) |=> s3_valid_ff)
      else $error("sum stage lost while the result register was stalled");

   // A nonnegative total never turns into a negative drive.
   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      (out_free && s3_valid_ff && !total_ff[ACC_W-1]) |=> !drive_ff[DRIVE_W-1])
      else $error("nonnegative total produced a negative drive");

endmodule
